### hw/rtl/c32ws_pkg.sv
// ----------------------------------------------------------------------------
// c32ws_pkg: shared types and constants for the CRC-32 word stream
// Holds the CRC word type, the seed, the polynomial and the row masks of the
// one-word update matrix (MSB first, no reflection, no final XOR).
// ----------------------------------------------------------------------------
package c32ws_pkg;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned IDX_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_crc_word;

    localparam t_crc_word CRC_INIT = 32'hFFFF_FFFF;
    localparam t_crc_word CRC_POLY = 32'h04C1_1DB7;
    localparam t_crc_word CRC_TOP  = 32'h8000_0000;

    // Bit i of the result is set when input bit i of (crc ^ word) feeds
    // output bit row of the CRC after one word.
    function automatic t_crc_word crc_row_mask(input int unsigned row);
        t_crc_word mask;
        t_crc_word col;
        mask = '0;
        for (int unsigned i = 0; i < WORD_BITS; i++) begin
            col = t_crc_word'(1) << i;
            for (int unsigned k = 0; k < WORD_BITS; k++) begin
                if ((col & CRC_TOP) != '0) begin
                    col = (col << 1) ^ CRC_POLY;
                end else begin
                    col = col << 1;
                end
            end
            mask[i[IDX_BITS-1:0]] = col[row[IDX_BITS-1:0]];
        end
        return mask;
    endfunction

endpackage

### hw/rtl/c32ws_absorb.sv
// ----------------------------------------------------------------------------
// c32ws_absorb: one-word CRC-32 update
// Absorbs a full 32-bit word in a single pass as a fixed XOR matrix over
// (crc ^ word), one parity tree per result bit.
// ----------------------------------------------------------------------------
module c32ws_absorb (
    input  c32ws_pkg::t_crc_word i_crc,
    input  c32ws_pkg::t_crc_word i_word,
    output c32ws_pkg::t_crc_word o_crc
);

    c32ws_pkg::t_crc_word w_mix;

    assign w_mix = i_crc ^ i_word;

    for (genvar j = 0; j < c32ws_pkg::WORD_BITS; j++) begin : g_row
        localparam c32ws_pkg::t_crc_word C_MASK = c32ws_pkg::crc_row_mask(j);
        assign o_crc[j] = ^(w_mix & C_MASK);
    end

endmodule

### hw/rtl/crc32_word_stream_top.sv
// ----------------------------------------------------------------------------
// crc32_word_stream_top: CRC-32/MPEG-2 over a stream of 32-bit words
// Running CRC per word with first/last marks; one result item per input item.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_data_word, i_first_word,
//                                                 i_last_word
//   out      output     o_out_valid / i_out_ready o_crc_value, o_crc_final
//
// One item per clock sustained while the result is not stalled.
// The word update is one XOR matrix between the input register and the CRC
// register, which doubles as the result register.
// Synchronous active-low reset seeds the CRC with all ones and empties both
// stages. A stalled result holds the CRC; one more item waits in the input
// register meanwhile.
// ----------------------------------------------------------------------------
module crc32_word_stream_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  c32ws_pkg::t_crc_word i_data_word,
    input  logic                 i_first_word,
    input  logic                 i_last_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output c32ws_pkg::t_crc_word o_crc_value,
    output logic                 o_crc_final
);

    logic                 r_in_valid;
    c32ws_pkg::t_crc_word r_in_data;
    logic                 r_in_first;
    logic                 r_in_last;

    logic                 r_out_valid;
    logic                 r_out_final;
    c32ws_pkg::t_crc_word r_crc;

    c32ws_pkg::t_crc_word w_base;
    c32ws_pkg::t_crc_word n_crc;
    logic                 w_move;
    logic                 w_take;

    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_move;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_base     = r_in_first ? c32ws_pkg::CRC_INIT : r_crc;

    c32ws_absorb u_absorb (
        .i_crc  (w_base),
        .i_word (r_in_data),
        .o_crc  (n_crc)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_data  <= i_data_word;
            r_in_first <= i_first_word;
            r_in_last  <= i_last_word;
        end
    end

    // result stage and running CRC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_crc       <= c32ws_pkg::CRC_INIT;
        end else begin
            if (w_move) begin
                r_out_valid <= 1'b1;
                r_crc       <= n_crc;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_final <= r_in_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_crc;
    assign o_crc_final = r_out_final;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_crc == c32ws_pkg::CRC_INIT) && !r_in_valid && !r_out_valid)
        else $error("reset did not seed CRC or empty stages");

    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid && (r_out_final == $past(r_in_last)))
        else $error("item lost between stages");

    a_take_fills_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_in_valid)
        else $error("accepted item not held");

    a_stall_holds_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_crc))
        else $error("CRC changed while result stalled");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for crc32_word_stream_top
// Drives message words with random gaps and random output stalls, predicts
// the running CRC-32/MPEG-2 of every word, and compares each result item with
// the oldest prediction. It covers directed corner words, well-formed
// messages, broken first/last marking, a long output hold-off and a run with
// no idling.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        c32ws_pkg::t_crc_word crc;
        logic                 last_mark;
    } t_crc_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    c32ws_pkg::t_crc_word i_data_word;
    logic                 i_first_word;
    logic                 i_last_word;
    logic                 o_out_valid;
    logic                 i_out_ready;
    c32ws_pkg::t_crc_word o_crc_value;
    logic                 o_crc_final;

    t_crc_result          crc_expect_q[$];
    c32ws_pkg::t_crc_word crc_running;
    int                   n_fail;
    bit                   tx_steady;
    bit                   rx_steady;
    int                   rx_hold_cycles;
    int                   rx_stall_left;

    crc32_word_stream_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_word  (i_data_word),
        .i_first_word (i_first_word),
        .i_last_word  (i_last_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_crc_value  (o_crc_value),
        .o_crc_final  (o_crc_final)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic c32ws_pkg::t_crc_word crc_absorb_word(
        input c32ws_pkg::t_crc_word crc,
        input c32ws_pkg::t_crc_word word
    );
        c32ws_pkg::t_crc_word c;
        c32ws_pkg::t_crc_word w;
        logic                 fb;
        c = crc;
        w = word;
        for (int k = 0; k < c32ws_pkg::WORD_BITS; k++) begin
            fb = c[c32ws_pkg::WORD_BITS-1] ^ w[c32ws_pkg::WORD_BITS-1];
            c  = c << 1;
            if (fb) begin
                c = c ^ c32ws_pkg::CRC_POLY;
            end
            w = w << 1;
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic c32ws_pkg::t_crc_word pick_word();
        int sel;
        int pos;
        sel = $urandom_range(0, 19);
        pos = $urandom_range(0, c32ws_pkg::WORD_BITS - 1);
        case (sel)
            0: return '0;
            1: return '1;
            2: return c32ws_pkg::t_crc_word'(1) << pos;
            3: return ~(c32ws_pkg::t_crc_word'(1) << pos);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input c32ws_pkg::t_crc_word word, input logic first,
                             input logic last);
        int          gap;
        t_crc_result res;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data_word  = word;
        i_first_word = first;
        i_last_word  = last;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (first) begin
            crc_running = c32ws_pkg::CRC_INIT;
        end
        crc_running   = crc_absorb_word(crc_running, word);
        res.crc       = crc_running;
        res.last_mark = last;
        crc_expect_q.push_back(res);
    endtask

    // hold input idle until every predicted item has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (crc_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++) begin
            send_word(pick_word(), k == 0, k == len - 1);
        end
    endtask

    task automatic test_directed();
        // no first mark right after reset
        send_word(32'h1234_5678, 1'b0, 1'b0);
        send_word(32'h9ABC_DEF0, 1'b0, 1'b1);
        // single-word messages
        send_word(32'h0000_0000, 1'b1, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_word(32'h8000_0000, 1'b1, 1'b1);
        send_word(32'h0000_0001, 1'b1, 1'b1);
        send_word(32'hAAAA_AAAA, 1'b1, 1'b1);
        send_word(32'h5555_5555, 1'b1, 1'b1);
        // multi-word message
        send_word(32'h3132_3334, 1'b1, 1'b0);
        send_word(32'h3536_3738, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b1);
        // words after the last mark
        send_word(32'hDEAD_BEEF, 1'b0, 1'b0);
        send_word(32'h0F0F_0F0F, 1'b0, 1'b0);
        send_word(32'hF0F0_F0F0, 1'b0, 1'b1);
        // restart in the middle of a message
        send_word(32'h0123_4567, 1'b1, 1'b0);
        send_word(32'h89AB_CDEF, 1'b1, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0, 1'b1);
        // first and last together follow a message without a last mark
        send_word(32'hFFFF_FFFE, 1'b1, 1'b0);
        send_word(32'h0000_0000, 1'b1, 1'b1);
        drain_results();
    endtask

    task automatic test_random_messages();
        int count;
        int len;
        count = 0;
        while (count < 1420) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
            send_message(len);
            count += len;
        end
        drain_results();
    endtask

    task automatic test_broken_marks();
        for (int k = 0; k < 300; k++) begin
            send_word(pick_word(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        end
        drain_results();
    endtask

    task automatic test_output_holdoff();
        tx_steady      = 1'b1;
        rx_hold_cycles = 300;
        for (int k = 0; k < 6; k++) begin
            send_message($urandom_range(4, 10));
        end
        tx_steady = 1'b0;
        drain_results();
    endtask

    task automatic test_no_idling();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int k = 0; k < 20; k++) begin
            send_message($urandom_range(1, 10));
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain_results();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_data_word    = '0;
        i_first_word   = 1'b0;
        i_last_word    = 1'b0;
        crc_running    = c32ws_pkg::CRC_INIT;
        n_fail         = 0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        rx_hold_cycles = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_messages();
        test_broken_marks();
        test_output_holdoff();
        test_no_idling();

        repeat (8) @(posedge i_clk);
        if (crc_expect_q.size() != 0) begin
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // result receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready   = 1'b0;
        rx_stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles != 0) begin
                i_out_ready = 1'b0;
                rx_hold_cycles--;
            end else if (rx_steady) begin
                i_out_ready = 1'b1;
            end else if (rx_stall_left != 0) begin
                i_out_ready = 1'b0;
                rx_stall_left--;
            end else begin
                i_out_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    rx_stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_crc_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (crc_expect_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("unexpected result item: crc=%08h final=%0b",
                             o_crc_value, o_crc_final);
                end
            end else begin
                exp_res = crc_expect_q.pop_front();
                if (o_crc_value !== exp_res.crc || o_crc_final !== exp_res.last_mark) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("mismatch: crc exp=%08h got=%08h final exp=%0b got=%0b",
                                 exp_res.crc, o_crc_value, exp_res.last_mark, o_crc_final);
                    end
                end
            end
        end
    end

endmodule
